/* rtl/sot_pkg.sv */
// sot_pkg: shared types and constants for the sphere overlap table.
// Used by sot_dist_unit and sphere_overlap_table; depends on nothing.

package sot_pkg;

  localparam int LayerCountDef = 10;
  localparam int EntriesDef    = 256;

  localparam int CoordW = 16;
  localparam int RadW   = 15;
  localparam int ModelW = 10;
  localparam int IdW    = 12;
  localparam int LayerW = 4;
  localparam int IndexW = 8;
  localparam int MagW   = 16;   // |a - b| of two 16-bit coordinates, or r1 + r2
  localparam int SqW    = 32;
  localparam int AccW   = 34;   // sum of three squares

  typedef enum logic [1:0] {
    CmdAdd      = 2'd0,
    CmdMove     = 2'd1,
    CmdQueryPt  = 2'd2,
    CmdQueryEnt = 2'd3
  } sot_cmd_e;

  typedef enum logic [1:0] {
    SelX = 2'd0,
    SelY = 2'd1,
    SelZ = 2'd2,
    SelR = 2'd3
  } sot_sel_e;

  typedef struct packed {
    logic     en;
    sot_sel_e sel;
  } sot_dctl_t;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StPchk  = 9'b000000010,
    StPload = 9'b000000100,
    StRd    = 9'b000001000,
    StMx    = 9'b000010000,
    StMy    = 9'b000100000,
    StMz    = 9'b001000000,
    StMr    = 9'b010000000,
    StDone  = 9'b100000000
  } sot_state_e;

endpackage

/* rtl/sot_dist_unit.sv */
// sot_dist_unit: shared square-and-accumulate unit for sphere overlap tests.
// One 16x16 multiply per step; depends on sot_pkg.

module sot_dist_unit import sot_pkg::*; (
  input  logic                     clk_i,
  input  sot_dctl_t                ctrl_i,
  input  logic signed [CoordW-1:0] p_x_i,
  input  logic signed [CoordW-1:0] p_y_i,
  input  logic signed [CoordW-1:0] p_z_i,
  input  logic        [RadW-1:0]   p_rad_i,
  input  logic signed [CoordW-1:0] e_x_i,
  input  logic signed [CoordW-1:0] e_y_i,
  input  logic signed [CoordW-1:0] e_z_i,
  input  logic        [RadW-1:0]   e_rad_i,
  output logic                     less_o
);

  logic signed [CoordW-1:0] a, b;
  logic signed [CoordW:0]   diff;
  logic        [CoordW:0]   diff_abs;
  logic        [MagW-1:0]   mag;
  logic        [SqW-1:0]    mul_q;
  logic        [AccW-1:0]   acc_q;

  always_comb begin
    a = p_x_i;
    b = e_x_i;
    case (ctrl_i.sel)
      SelX:    begin a = p_x_i; b = e_x_i; end
      SelY:    begin a = p_y_i; b = e_y_i; end
      SelZ:    begin a = p_z_i; b = e_z_i; end
      default: begin a = p_x_i; b = e_x_i; end
    endcase
    diff     = (CoordW+1)'(a) - (CoordW+1)'(b);
    diff_abs = diff[CoordW] ? (CoordW+1)'(-diff) : diff;
    if (ctrl_i.sel == SelR) begin
      mag = MagW'(p_rad_i) + MagW'(e_rad_i);
    end else begin
      mag = diff_abs[MagW-1:0];
    end
  end

  // acc holds x^2 + y^2 + z^2 once the radius square sits in mul_q
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      mul_q <= mag * mag;
      if (ctrl_i.sel == SelX) begin
        acc_q <= '0;
      end else begin
        acc_q <= acc_q + AccW'(mul_q);
      end
    end
  end

  assign less_o = acc_q < AccW'(mul_q);

endmodule

/* rtl/sphere_overlap_table.sv */
// sphere_overlap_table: per-layer sphere tables with add, move and overlap queries.
// Depends on sot_pkg and sot_dist_unit.
//
// Usage: commands arrive on the s_axis channel, cmd in tuser, the other fields
// in tdata. Every transaction gives exactly one result transaction on m_axis.
// Add and move finish in the accepting cycle; the result is registered and
// shows in the cycle after. A point query compares the layer's entries in
// order up to the hitting one, at most the layer's fill; a stored-entry query
// first fetches its probe. The single multiplier squares dx, dy, dz and the
// radius sum one after another for each entry read from the sphere memory.
// The block takes one command at a time; tready is low while a query walks.
// A pending result is held while m_axis_tready is low, and no new command is
// taken until the output register can accept its result.
// Reset empties every layer and restarts the id counter at zero; the sphere
// memories are not cleared, entries beyond a layer's fill are never read.

module sphere_overlap_table import sot_pkg::*; #(
  parameter int LAYER_COUNT       = LayerCountDef,
  parameter int ENTRIES_PER_LAYER = EntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // layer, self_layer, entry_index, model_id, pos_x, pos_y, pos_z, radius, 7 zero bits
  input  logic [95:0] s_axis_tdata,
  // cmd
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hit, hit_model, new_id, layer_full
  output logic [23:0] m_axis_tdata
);

  localparam int Depth = LAYER_COUNT * ENTRIES_PER_LAYER;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int LW    = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int CW    = $clog2(ENTRIES_PER_LAYER + 1);
  localparam int EW    = $clog2(ENTRIES_PER_LAYER);
  localparam int CMPW  = (CW > IndexW) ? CW : IndexW;
  localparam int LCW   = LayerW + 1;
  localparam int PosW  = 3 * CoordW;
  localparam int RmW   = RadW + ModelW;

  // input fields
  sot_cmd_e                 in_cmd;
  logic        [LayerW-1:0] in_layer;
  logic        [LayerW-1:0] in_self_layer;
  logic        [IndexW-1:0] in_index;
  logic        [ModelW-1:0] in_model;
  logic signed [CoordW-1:0] in_x, in_y, in_z;
  logic        [RadW-1:0]   in_rad;

  assign in_cmd        = sot_cmd_e'(s_axis_tuser);
  assign in_layer      = s_axis_tdata[3:0];
  assign in_self_layer = s_axis_tdata[7:4];
  assign in_index      = s_axis_tdata[15:8];
  assign in_model      = s_axis_tdata[25:16];
  assign in_x          = s_axis_tdata[41:26];
  assign in_y          = s_axis_tdata[57:42];
  assign in_z          = s_axis_tdata[73:58];
  assign in_rad        = s_axis_tdata[88:74];

  // control state
  sot_state_e      state_q, state_d;
  logic [CW-1:0]   cnt_q [LAYER_COUNT];
  logic [CW-1:0]   cnt_d [LAYER_COUNT];
  logic [IdW-1:0]  next_id_q, next_id_d;
  logic            out_vld_q, out_vld_d;
  // one-cycle flag marking the compare slot after the radius step
  logic            cmp_q;

  // working registers
  logic [AW-1:0]            base_q, base_d;
  logic [CW-1:0]            n_q, n_d;
  logic [CW-1:0]            i_q, i_d;
  logic [LayerW-1:0]        lay_q, lay_d;
  logic [LayerW-1:0]        sl_q, sl_d;
  logic [IndexW-1:0]        idx_q, idx_d;
  logic                     skip_en_q, skip_en_d;
  logic signed [CoordW-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic        [RadW-1:0]   pr_q, pr_d;
  logic                     res_hit_q, res_hit_d;
  logic        [ModelW-1:0] res_model_q, res_model_d;
  logic                     out_hit_q, out_hit_d;
  logic        [ModelW-1:0] out_model_q, out_model_d;
  logic        [IdW-1:0]    out_id_q, out_id_d;
  logic                     out_full_q, out_full_d;

  // sphere memories
  logic [PosW-1:0] pos_mem [Depth];
  logic [RmW-1:0]  rm_mem  [Depth];
  logic [PosW-1:0] pos_rd_q;
  logic [RmW-1:0]  rm_rd_q;
  logic            pos_we, rm_we, rd_en;
  logic [AW-1:0]   waddr, raddr;

  // layer selection, one count read port
  logic [LayerW-1:0] lsel;
  logic              lsel_ok;
  logic [LW-1:0]     lsel_idx;
  logic [CW-1:0]     cnt_sel;
  logic [AW-1:0]     base_sel;

  logic            in_acc;
  logic            out_free;
  sot_dctl_t       dctl;
  logic            less;

  logic signed [CoordW-1:0] e_x, e_y, e_z;
  logic        [RadW-1:0]   e_rad;
  logic        [ModelW-1:0] e_model;

  assign e_x     = pos_rd_q[CoordW-1:0];
  assign e_y     = pos_rd_q[2*CoordW-1:CoordW];
  assign e_z     = pos_rd_q[3*CoordW-1:2*CoordW];
  assign e_rad   = rm_rd_q[RadW-1:0];
  assign e_model = rm_rd_q[RmW-1:RadW];

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign lsel     = (state_q == StPchk) ? sl_q : in_layer;
  assign lsel_ok  = LCW'(lsel) < LCW'(LAYER_COUNT);
  assign lsel_idx = lsel[LW-1:0];
  assign cnt_sel  = cnt_q[lsel_idx];
  assign base_sel = AW'(lsel_idx) * AW'(ENTRIES_PER_LAYER);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    next_id_d   = next_id_q;
    out_vld_d   = out_vld_q;
    base_d      = base_q;
    n_d         = n_q;
    i_d         = i_q;
    lay_d       = lay_q;
    sl_d        = sl_q;
    idx_d       = idx_q;
    skip_en_d   = skip_en_q;
    px_d        = px_q;
    py_d        = py_q;
    pz_d        = pz_q;
    pr_d        = pr_q;
    res_hit_d   = res_hit_q;
    res_model_d = res_model_q;
    out_hit_d   = out_hit_q;
    out_model_d = out_model_q;
    out_id_d    = out_id_q;
    out_full_d  = out_full_q;
    pos_we      = 1'b0;
    rm_we       = 1'b0;
    waddr       = base_sel;
    rd_en       = 1'b0;
    raddr       = base_q + AW'(i_q[EW-1:0]);
    dctl.en     = 1'b0;
    dctl.sel    = SelX;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          lay_d       = in_layer;
          sl_d        = in_self_layer;
          idx_d       = in_index;
          px_d        = in_x;
          py_d        = in_y;
          pz_d        = in_z;
          pr_d        = in_rad;
          base_d      = base_sel;
          n_d         = cnt_sel;
          i_d         = '0;
          skip_en_d   = 1'b0;
          res_hit_d   = 1'b0;
          res_model_d = '0;
          case (in_cmd)
            CmdAdd: begin
              out_vld_d   = 1'b1;
              out_hit_d   = 1'b0;
              out_model_d = '0;
              if (!lsel_ok || cnt_sel == CW'(ENTRIES_PER_LAYER)) begin
                out_id_d   = '0;
                out_full_d = 1'b1;
              end else begin
                pos_we              = 1'b1;
                rm_we               = 1'b1;
                waddr               = base_sel + AW'(cnt_sel[EW-1:0]);
                cnt_d[lsel_idx]     = cnt_sel + CW'(1);
                out_id_d            = next_id_q;
                out_full_d          = 1'b0;
                next_id_d           = next_id_q + IdW'(1);
              end
            end
            CmdMove: begin
              out_vld_d   = 1'b1;
              out_hit_d   = 1'b0;
              out_model_d = '0;
              out_id_d    = '0;
              out_full_d  = 1'b0;
              if (lsel_ok && CMPW'(in_index) < CMPW'(cnt_sel)) begin
                pos_we = 1'b1;
                waddr  = base_sel + AW'(in_index);
              end
            end
            CmdQueryPt: begin
              state_d = lsel_ok ? StRd : StDone;
            end
            default: begin
              state_d = lsel_ok ? StPchk : StDone;
            end
          endcase
        end
      end
      StPchk: begin
        // probe entry must exist in its own layer
        if (lsel_ok && CMPW'(idx_q) < CMPW'(cnt_sel)) begin
          rd_en     = 1'b1;
          raddr     = base_sel + AW'(idx_q);
          skip_en_d = (sl_q == lay_q);
          state_d   = StPload;
        end else begin
          state_d = StDone;
        end
      end
      StPload: begin
        px_d    = e_x;
        py_d    = e_y;
        pz_d    = e_z;
        pr_d    = e_rad;
        state_d = StRd;
      end
      StRd: begin
        if (CMPW'(i_q) >= CMPW'(n_q)) begin
          state_d = StDone;
        end else if (skip_en_q && CMPW'(i_q) == CMPW'(idx_q)) begin
          i_d = i_q + CW'(1);
        end else begin
          rd_en   = 1'b1;
          state_d = StMx;
        end
      end
      StMx: begin
        dctl.en  = 1'b1;
        dctl.sel = SelX;
        state_d  = StMy;
      end
      StMy: begin
        dctl.en  = 1'b1;
        dctl.sel = SelY;
        state_d  = StMz;
      end
      StMz: begin
        dctl.en  = 1'b1;
        dctl.sel = SelZ;
        state_d  = StMr;
      end
      StMr: begin
        dctl.en  = 1'b1;
        dctl.sel = SelR;
        state_d  = StDone;
        // compare happens below, in StMr again while cmp_q is set
      end
      StDone: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_hit_d   = res_hit_q;
          out_model_d = res_model_q;
          out_id_d    = '0;
          out_full_d  = 1'b0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // distance sum and radius square are ready in the cycle after the radius step
    if (state_q == StMr) begin
      state_d = StMr;
    end
    if (cmp_q) begin
      if (less) begin
        res_hit_d   = 1'b1;
        res_model_d = e_model;
        state_d     = StDone;
      end else begin
        i_d     = i_q + CW'(1);
        state_d = StRd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '{default: '0};
      next_id_q <= '0;
      out_vld_q <= 1'b0;
      cmp_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      next_id_q <= next_id_d;
      out_vld_q <= out_vld_d;
      cmp_q     <= (state_q == StMr) && !cmp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q      <= base_d;
    n_q         <= n_d;
    i_q         <= i_d;
    lay_q       <= lay_d;
    sl_q        <= sl_d;
    idx_q       <= idx_d;
    skip_en_q   <= skip_en_d;
    px_q        <= px_d;
    py_q        <= py_d;
    pz_q        <= pz_d;
    pr_q        <= pr_d;
    res_hit_q   <= res_hit_d;
    res_model_q <= res_model_d;
    out_hit_q   <= out_hit_d;
    out_model_q <= out_model_d;
    out_id_q    <= out_id_d;
    out_full_q  <= out_full_d;
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[waddr] <= {in_z, in_y, in_x};
    end
    if (rd_en) begin
      pos_rd_q <= pos_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rm_we) begin
      rm_mem[waddr] <= {in_model, in_rad};
    end
    if (rd_en) begin
      rm_rd_q <= rm_mem[raddr];
    end
  end

  sot_dist_unit u_dist (
    .clk_i   (clk_i),
    .ctrl_i  (dctl),
    .p_x_i   (px_q),
    .p_y_i   (py_q),
    .p_z_i   (pz_q),
    .p_rad_i (pr_q),
    .e_x_i   (e_x),
    .e_y_i   (e_y),
    .e_z_i   (e_z),
    .e_rad_i (e_rad),
    .less_o  (less)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_full_q, out_id_q, out_model_q, out_hit_q};

endmodule

/* verif/tb_sphere_overlap_table.sv */
// tb_sphere_overlap_table: self-checking bench for the sphere overlap table.
// Tracks the layer tables in a class and compares every m_axis transaction in order.
// Depends on sot_pkg and the sphere_overlap_table RTL.

module tb_sphere_overlap_table;
  import sot_pkg::*;

  localparam int          Layers      = LayerCountDef;
  localparam int          Entries     = EntriesDef;
  localparam int unsigned CycleLimit  = 20_000_000;
  localparam int          RandomItems = 1070;

  // s_axis_tdata layout, lowest field last
  typedef struct packed {
    logic [6:0]         pad;
    logic [RadW-1:0]    radius;
    logic signed [15:0] pos_z;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_x;
    logic [ModelW-1:0]  model_id;
    logic [IndexW-1:0]  entry_index;
    logic [LayerW-1:0]  self_layer;
    logic [LayerW-1:0]  layer;
  } sphere_cmd_t;

  // m_axis_tdata layout, lowest field last
  typedef struct packed {
    logic              layer_full;
    logic [IdW-1:0]    new_id;
    logic [ModelW-1:0] hit_model;
    logic              hit;
  } overlap_answer_t;

  class sphere_tables;
    int unsigned        fill [Layers];
    logic signed [15:0] cx [Layers][Entries];
    logic signed [15:0] cy [Layers][Entries];
    logic signed [15:0] cz [Layers][Entries];
    logic [RadW-1:0]    rad [Layers][Entries];
    logic [ModelW-1:0]  mdl [Layers][Entries];
    logic [IdW-1:0]     id_ctr;
    overlap_answer_t    answers_due [$];
    int unsigned        answers_seen, mismatches, overlaps, refusals, commands;

    function new();
      foreach (fill[i]) fill[i] = 0;
      id_ctr = '0;
    endfunction

    static function longint unsigned sq_gap(logic signed [15:0] a, logic signed [15:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return longint'(d * d);
    endfunction

    // first entry of a layer strictly inside the probe's reach; skip < 0 skips nothing
    function automatic bit first_overlap(input int lay, input logic signed [15:0] x,
                                         input logic signed [15:0] y,
                                         input logic signed [15:0] z,
                                         input logic [RadW-1:0] r, input int skip,
                                         output logic [ModelW-1:0] m);
      longint unsigned gap2, reach;
      m = '0;
      for (int i = 0; i < int'(fill[lay]); i++) begin
        if (i == skip) continue;
        gap2  = sq_gap(x, cx[lay][i]) + sq_gap(y, cy[lay][i]) + sq_gap(z, cz[lay][i]);
        reach = longint'(r) + longint'(rad[lay][i]);
        if (gap2 < reach * reach) begin
          m = mdl[lay][i];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function automatic void take_command(sot_cmd_e op, sphere_cmd_t c);
      overlap_answer_t a;
      logic [ModelW-1:0] m;
      int n;
      a = '0;
      m = '0;
      commands++;
      case (op)
        CmdAdd: begin
          if (c.layer >= Layers || fill[c.layer] >= Entries) begin
            a.layer_full = 1'b1;
            refusals++;
          end else begin
            n = fill[c.layer];
            cx[c.layer][n]  = c.pos_x;
            cy[c.layer][n]  = c.pos_y;
            cz[c.layer][n]  = c.pos_z;
            rad[c.layer][n] = c.radius;
            mdl[c.layer][n] = c.model_id;
            fill[c.layer]++;
            a.new_id = id_ctr;
            id_ctr++;
          end
        end
        CmdMove: begin
          if (c.layer < Layers && c.entry_index < fill[c.layer]) begin
            cx[c.layer][c.entry_index] = c.pos_x;
            cy[c.layer][c.entry_index] = c.pos_y;
            cz[c.layer][c.entry_index] = c.pos_z;
          end
        end
        CmdQueryPt: begin
          if (c.layer < Layers)
            a.hit = first_overlap(c.layer, c.pos_x, c.pos_y, c.pos_z, c.radius, -1, m);
        end
        default: begin
          if (c.layer < Layers && c.self_layer < Layers &&
              c.entry_index < fill[c.self_layer]) begin
            n = c.entry_index;
            a.hit = first_overlap(c.layer, cx[c.self_layer][n], cy[c.self_layer][n],
                                  cz[c.self_layer][n], rad[c.self_layer][n],
                                  (c.self_layer == c.layer) ? n : -1, m);
          end
        end
      endcase
      if (a.hit) begin
        a.hit_model = m;
        overlaps++;
      end
      answers_due.insert(answers_due.size(), a);
    endfunction

    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
      $display("MISMATCH answer %0d %s: got 0x%0h, want 0x%0h",
               answers_seen, what, got, want);
      mismatches++;
    endtask

    task automatic check_answer(overlap_answer_t got);
      overlap_answer_t want;
      answers_seen++;
      if (answers_due.size() == 0) begin
        flag_mismatch("unrequested transaction", got, 0);
        return;
      end
      want = answers_due.pop_front();
      if (got.hit !== want.hit) flag_mismatch("hit", got.hit, want.hit);
      if (got.hit_model !== want.hit_model)
        flag_mismatch("hit_model", got.hit_model, want.hit_model);
      if (got.new_id !== want.new_id) flag_mismatch("new_id", got.new_id, want.new_id);
      if (got.layer_full !== want.layer_full)
        flag_mismatch("layer_full", got.layer_full, want.layer_full);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  sphere_tables tables;
  bit           quiet;
  bit           held;
  int unsigned  cycles;

  sphere_overlap_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tables.check_answer(m_axis_tdata);
  end

  // result side: random back-pressure plus one long hold-off mid-run
  initial begin
    m_axis_tready = 1'b0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && tables != null && tables.answers_seen >= 600) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (700) @(negedge clk_i);
      end
      m_axis_tready <= quiet || ($urandom_range(99) >= 28);
    end
  end

  task automatic send_command(input sot_cmd_e op, input sphere_cmd_t c);
    while (!quiet && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= c;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    tables.take_command(op, c);
    @(negedge clk_i);
  endtask

  task automatic send_fields(input sot_cmd_e op, input int lay, input int self_lay,
                             input int idx, input int model, input int x, input int y,
                             input int z, input int r);
    sphere_cmd_t c;
    c = '0;
    c.layer       = lay[LayerW-1:0];
    c.self_layer  = self_lay[LayerW-1:0];
    c.entry_index = idx[IndexW-1:0];
    c.model_id    = model[ModelW-1:0];
    c.pos_x       = x[15:0];
    c.pos_y       = y[15:0];
    c.pos_z       = z[15:0];
    c.radius      = r[RadW-1:0];
    send_command(op, c);
  endtask

  // mostly a tight cluster so spheres actually meet, sometimes anywhere
  function automatic logic signed [15:0] rand_coord();
    int v;
    if ($urandom_range(99) < 70) v = int'($urandom_range(4000)) - 2000;
    else v = int'($urandom);
    return v[15:0];
  endfunction

  function automatic logic [RadW-1:0] rand_radius();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return RadW'($urandom_range(1500));
    if (p < 90) return RadW'($urandom_range(32767));
    return RadW'($urandom_range(40));
  endfunction

  function automatic logic [LayerW-1:0] rand_layer();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 85) return LayerW'($urandom_range(Layers - 2));
    if (p < 90) return LayerW'(Layers - 1);
    return LayerW'($urandom_range(15, Layers));
  endfunction

  function automatic logic [IndexW-1:0] rand_index(int lay);
    if (lay < Layers && tables.fill[lay] > 0 && $urandom_range(99) < 85)
      return IndexW'($urandom_range(tables.fill[lay] - 1));
    return IndexW'($urandom);
  endfunction

  task automatic send_random_command();
    sphere_cmd_t c;
    sot_cmd_e    op;
    int unsigned p;
    int          n, off;
    c = '0;
    c.model_id    = ModelW'($urandom);
    c.self_layer  = LayerW'($urandom);
    c.entry_index = IndexW'($urandom);
    c.pos_x       = rand_coord();
    c.pos_y       = rand_coord();
    c.pos_z       = rand_coord();
    c.radius      = rand_radius();
    c.layer       = rand_layer();
    p = $urandom_range(99);
    op = (p < 30) ? CmdAdd : (p < 48) ? CmdMove : (p < 78) ? CmdQueryPt : CmdQueryEnt;
    case (op)
      CmdMove: c.entry_index = rand_index(c.layer);
      CmdQueryPt: begin
        // aim near a stored centre now and then, so hits land deep in the walk
        if (c.layer < Layers && tables.fill[c.layer] > 0 && $urandom_range(99) < 35) begin
          n   = $urandom_range(tables.fill[c.layer] - 1);
          off = int'($urandom_range(200)) - 100;
          c.pos_x = 16'(int'(tables.cx[c.layer][n]) + off);
          c.pos_y = 16'(int'(tables.cy[c.layer][n]) - off);
          c.pos_z = tables.cz[c.layer][n];
        end
      end
      CmdQueryEnt: begin
        c.self_layer  = ($urandom_range(99) < 90) ? LayerW'($urandom_range(Layers - 1))
                                                  : LayerW'($urandom_range(15, Layers));
        c.entry_index = rand_index(c.self_layer);
        if ($urandom_range(99) < 45) c.layer = c.self_layer;
      end
      default: ;
    endcase
    send_command(op, c);
  endtask

  initial begin
    tables        = new();
    quiet         = 1'b0;
    cycles        = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CmdAdd;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, refusals, ignored moves, self skip
    send_fields(CmdAdd, 0, 0, 0, 5, 0, 0, 0, 1600);
    send_fields(CmdAdd, 0, 15, 255, 1023, 32767, 32767, 32767, 32767);
    send_fields(CmdAdd, 0, 0, 0, 0, -32768, -32768, -32768, 0);
    send_fields(CmdAdd, 0, 0, 0, 700, 20, -20, 10, 16);
    send_fields(CmdAdd, 12, 0, 0, 9, 0, 0, 0, 10);
    send_fields(CmdQueryPt, 0, 0, 0, 0, 0, 0, 0, 0);
    // zero radii on a coincident centre: strictly-below test must miss
    send_fields(CmdQueryPt, 0, 0, 0, 0, -32768, -32768, -32768, 0);
    send_fields(CmdQueryPt, 0, 0, 0, 0, -32768, -32768, -32768, 1);
    send_fields(CmdQueryPt, 15, 0, 0, 0, 0, 0, 0, 32767);
    send_fields(CmdQueryPt, 1, 0, 0, 0, 0, 0, 0, 32767);
    send_fields(CmdQueryEnt, 0, 0, 0, 0, 0, 0, 0, 0);
    send_fields(CmdQueryEnt, 0, 0, 3, 0, 0, 0, 0, 0);
    send_fields(CmdQueryEnt, 0, 0, 4, 0, 0, 0, 0, 0);
    send_fields(CmdQueryEnt, 0, 11, 0, 0, 0, 0, 0, 0);
    send_fields(CmdQueryEnt, 13, 0, 1, 0, 0, 0, 0, 0);
    send_fields(CmdMove, 0, 0, 1, 0, 0, 0, 0, 0);
    send_fields(CmdMove, 0, 0, 200, 0, 5, 5, 5, 0);
    send_fields(CmdMove, 14, 0, 0, 0, 5, 5, 5, 0);
    send_fields(CmdQueryPt, 0, 0, 0, 0, 0, 0, 0, 0);
    send_fields(CmdAdd, 3, 0, 0, 31, 100, 100, 100, 50);
    send_fields(CmdAdd, 3, 0, 0, 32, 100, 100, 100, 50);
    send_fields(CmdQueryEnt, 3, 3, 0, 0, 0, 0, 0, 0);
    send_fields(CmdQueryEnt, 3, 0, 2, 0, 0, 0, 0, 0);
    send_fields(CmdQueryEnt, 0, 3, 1, 0, 0, 0, 0, 0);

    // fill the top layer to capacity, then one add too many
    for (int i = 0; i <= Entries; i++)
      send_fields(CmdAdd, Layers - 1, 0, 0, int'($urandom), rand_coord(), rand_coord(),
                  rand_coord(), rand_radius());

    for (int i = 0; i < RandomItems; i++) begin
      quiet = (i >= 400 && i < 650);
      send_random_command();
    end
    quiet = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (tables.answers_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Ran %0d commands over %0d cycles: %0d overlaps reported, %0d adds refused.",
             tables.commands, cycles, tables.overlaps, tables.refusals);
    $display("Layer fills at end: %p", tables.fill);
    if (tables.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", tables.mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sot_pkg.sv
rtl/sot_dist_unit.sv
rtl/sphere_overlap_table.sv
verif/tb_sphere_overlap_table.sv
